>>> rtl/core/bdlp_pkg.sv
// Package for the button debouncer with long-press detection.
// Holds counter widths, register indexes and the per-button status struct.
// No dependencies.
`default_nettype none

package bdlp_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int NUM_BUTTONS = 3;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = CFG_WIDTH'(30);
    localparam logic [CFG_WIDTH-1:0] HOLD_RESET     = CFG_WIDTH'(1500);

    typedef enum logic [0:0] {
        CFG_DEBOUNCE = 1'b0,
        CFG_HOLD     = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic stable;
        logic rise;
        logic fall;
        logic active;
    } btn_status_t;

endpackage

`default_nettype wire

>>> rtl/core/bdlp_button.sv
// Debounce filter for one active-low button.
// Depends on bdlp_pkg for the counter width and the status struct.
`default_nettype none

module bdlp_button (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               raw,
    input  wire logic [bdlp_pkg::CFG_WIDTH-1:0]     debounce_ticks,
    output bdlp_pkg::btn_status_t                   status
);

    logic                                last_raw_reg;
    logic                                stable_reg;
    logic                                active_reg;
    logic [bdlp_pkg::COUNT_WIDTH-1:0]    quiet_reg;
    logic [bdlp_pkg::COUNT_WIDTH-1:0]    quiet_next;
    logic                                take;

    always_comb
    begin
        if (raw != last_raw_reg)
        begin
            quiet_next = '0;
        end
        else if (quiet_reg == bdlp_pkg::COUNT_MAX)
        begin
            quiet_next = quiet_reg;
        end
        else
        begin
            quiet_next = quiet_reg + 1'b1;
        end
        take          = (quiet_next >= debounce_ticks) && (raw != stable_reg);
        status.stable = take ? raw : stable_reg;
        status.rise   = take && raw;
        status.fall   = take && !raw;
        status.active = take ? !raw : active_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= 1'b1;
            stable_reg   <= 1'b1;
            active_reg   <= 1'b0;
            quiet_reg    <= '0;
        end
        else if (en)
        begin
            last_raw_reg <= raw;
            stable_reg   <= status.stable;
            active_reg   <= status.active;
            quiet_reg    <= quiet_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bdlp_hold.sv
// Long-press timer for the minus button.
// Depends on bdlp_pkg for the counter width and the status struct.
`default_nettype none

module bdlp_hold (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire bdlp_pkg::btn_status_t              minus,
    input  wire logic [bdlp_pkg::CFG_WIDTH-1:0]     hold_ticks,
    output logic                                    long_ev,
    output logic                                    long_fired_next
);

    logic [bdlp_pkg::COUNT_WIDTH-1:0]    hold_reg;
    logic [bdlp_pkg::COUNT_WIDTH-1:0]    hold_next;
    logic                                long_fired_reg;
    logic                                fired_base;

    always_comb
    begin
        if (minus.fall)
        begin
            hold_next = '0;
        end
        else if (minus.active && (hold_reg != bdlp_pkg::COUNT_MAX))
        begin
            hold_next = hold_reg + 1'b1;
        end
        else
        begin
            hold_next = hold_reg;
        end
        fired_base      = minus.fall ? 1'b0 : long_fired_reg;
        long_ev         = minus.active && !fired_base && (hold_next >= hold_ticks);
        long_fired_next = fired_base || long_ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg       <= '0;
            long_fired_reg <= 1'b0;
        end
        else if (en)
        begin
            hold_reg       <= hold_next;
            long_fired_reg <= long_fired_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (en && long_ev) |=> long_fired_reg)
        else $error("long press fired but was not recorded");

    assert property (@(posedge clk) disable iff (!rst_n)
        (en && long_ev) |-> minus.active)
        else $error("long press fired without an active press");

    assert property (@(posedge clk) disable iff (!rst_n)
        (long_fired_reg && !minus.fall) |-> !long_ev)
        else $error("long press fired twice in one press");

endmodule

`default_nettype wire

>>> rtl/core/button_debounce_long_press.sv
// A word accepted into the input register is debounced, and its result word lands in the result register.
// Throughput: one word per cycle; the input register loads whenever it is empty
// or the result register is empty or being taken, so in_stall is high only
// while both registers hold words and out_stall is high.
// Reset: asynchronous, active low; buttons read as released, counters clear,
// debounce_ticks returns to 30 and hold_ticks to 1500.
`default_nettype none

module button_debounce_long_press (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [bdlp_pkg::CFG_WIDTH-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               raw_next,
    input  wire logic                               raw_plus,
    input  wire logic                               raw_minus,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    click_next,
    output logic                                    click_plus,
    output logic                                    click_minus,
    output logic                                    long_minus
);

    logic [bdlp_pkg::CFG_WIDTH-1:0]      debounce_reg;
    logic [bdlp_pkg::CFG_WIDTH-1:0]      hold_ticks_reg;
    logic                                in_valid_reg;
    logic [bdlp_pkg::NUM_BUTTONS-1:0]    raw_reg;
    logic                                out_valid_reg;
    logic                                click_next_reg;
    logic                                click_plus_reg;
    logic                                click_minus_reg;
    logic                                long_minus_reg;
    logic                                advance;
    logic                                load_in;
    logic                                step;
    logic                                long_ev;
    logic                                long_fired_next;
    bdlp_pkg::btn_status_t               st_next;
    bdlp_pkg::btn_status_t               st_plus;
    bdlp_pkg::btn_status_t               st_minus;

    assign advance   = !out_valid_reg || !out_stall;
    assign load_in   = !in_valid_reg || advance;
    assign step      = in_valid_reg && advance;
    assign in_stall  = !load_in;
    assign out_valid = out_valid_reg;
    assign click_next  = click_next_reg;
    assign click_plus  = click_plus_reg;
    assign click_minus = click_minus_reg;
    assign long_minus  = long_minus_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= bdlp_pkg::DEBOUNCE_RESET;
            hold_ticks_reg <= bdlp_pkg::HOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (bdlp_pkg::cfg_index_t'(cfg_index))
                bdlp_pkg::CFG_DEBOUNCE: debounce_reg   <= cfg_data;
                bdlp_pkg::CFG_HOLD:     hold_ticks_reg <= cfg_data;
                default:                debounce_reg   <= debounce_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_in)
            begin
                in_valid_reg  <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in && in_valid)
        begin
            raw_reg <= {raw_minus, raw_plus, raw_next};
        end
        if (step)
        begin
            click_next_reg  <= st_next.rise;
            click_plus_reg  <= st_plus.rise;
            click_minus_reg <= st_minus.rise && !long_fired_next;
            long_minus_reg  <= long_ev;
        end
    end

    bdlp_button u_btn_next (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (step),
        .raw            (raw_reg[0]),
        .debounce_ticks (debounce_reg),
        .status         (st_next)
    );

    bdlp_button u_btn_plus (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (step),
        .raw            (raw_reg[1]),
        .debounce_ticks (debounce_reg),
        .status         (st_plus)
    );

    bdlp_button u_btn_minus (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (step),
        .raw            (raw_reg[2]),
        .debounce_ticks (debounce_reg),
        .status         (st_minus)
    );

    bdlp_hold u_hold (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (step),
        .minus           (st_minus),
        .hold_ticks      (hold_ticks_reg),
        .long_ev         (long_ev),
        .long_fired_next (long_fired_next)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid_reg && click_minus_reg && long_minus_reg))
        else $error("minus click and long press in the same word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_valid_reg)
        else $error("accepted word was not captured");

    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed word did not reach the result register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("result word dropped while stalled");

endmodule

`default_nettype wire

>>> sim/button_debounce_long_press_tb.sv
// Self-checking testbench for the three-button debouncer with long-press detection.
// Drives tick words with random gaps and stalls and checks every result word
// against an in-bench predictor. Depends on bdlp_pkg and button_debounce_long_press.
module button_debounce_long_press_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BTN_MINUS = 2;

    typedef struct {
        logic [2:0]  raw;
        int unsigned gap;
    } tick_word_t;

    typedef struct packed {
        logic click_next;
        logic click_plus;
        logic click_minus;
        logic long_minus;
    } tick_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic                           cfg_index = 1'b0;
    logic [bdlp_pkg::CFG_WIDTH-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           raw_next = 1'b1;
    logic                           raw_plus = 1'b1;
    logic                           raw_minus = 1'b1;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic                           click_next;
    logic                           click_plus;
    logic                           click_minus;
    logic                           long_minus;

    button_debounce_long_press dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .raw_next    (raw_next),
        .raw_plus    (raw_plus),
        .raw_minus   (raw_minus),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .click_next  (click_next),
        .click_plus  (click_plus),
        .click_minus (click_minus),
        .long_minus  (long_minus)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Predictor state; per-button entries are ordered next, plus, minus.
    logic [bdlp_pkg::CFG_WIDTH-1:0]   debounce_cfg;
    logic [bdlp_pkg::CFG_WIDTH-1:0]   hold_cfg;
    logic [2:0]                       seen_raw;
    logic [2:0]                       settled;
    logic [2:0]                       settled_prev;
    logic [2:0]                       pressed;
    logic [bdlp_pkg::COUNT_WIDTH-1:0] quiet_ticks [3];
    logic [bdlp_pkg::COUNT_WIDTH-1:0] minus_held;
    logic                             long_done;

    tick_word_t   tick_queue[$];
    tick_result_t click_forecast[$];
    int unsigned  queued_count = 0;
    int unsigned  accepted_count = 0;
    int unsigned  error_count = 0;
    int unsigned  tx_max_gap = 0;
    int unsigned  rx_max_gap = 0;
    int unsigned  hold_ticket = 0;
    int unsigned  hold_seen = 0;
    int unsigned  hold_left = 0;
    int unsigned  rx_wait = 0;
    logic         word_accepted = 1'b0;
    logic         result_taken = 1'b0;

    function automatic void reset_predictor();
        debounce_cfg = bdlp_pkg::DEBOUNCE_RESET;
        hold_cfg     = bdlp_pkg::HOLD_RESET;
        seen_raw     = 3'b111;
        settled      = 3'b111;
        settled_prev = 3'b111;
        pressed      = 3'b000;
        for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++)
        begin
            quiet_ticks[b] = '0;
        end
        minus_held = '0;
        long_done  = 1'b0;
    endfunction

    function automatic tick_result_t debounce_tick(input logic [2:0] raw);
        tick_result_t res;
        logic [2:0]   click;
        logic         long_ev;
        logic         started;
        long_ev = 1'b0;
        for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++)
        begin
            started = 1'b0;
            if (raw[b] != seen_raw[b])
            begin
                quiet_ticks[b] = '0;
                seen_raw[b] = raw[b];
            end
            else if (quiet_ticks[b] != bdlp_pkg::COUNT_MAX)
            begin
                quiet_ticks[b] = quiet_ticks[b] + 1'b1;
            end
            if (quiet_ticks[b] >= debounce_cfg && raw[b] != settled[b])
            begin
                settled[b] = raw[b];
                if (!raw[b])
                begin
                    pressed[b] = 1'b1;
                    if (b == BTN_MINUS)
                    begin
                        long_done  = 1'b0;
                        minus_held = '0;
                    end
                    started = 1'b1;
                end
                else
                begin
                    pressed[b] = 1'b0;
                end
            end
            if (b == BTN_MINUS)
            begin
                if (pressed[b] && !started && minus_held != bdlp_pkg::COUNT_MAX)
                    minus_held = minus_held + 1'b1;
                if (pressed[b] && !long_done && minus_held >= hold_cfg)
                begin
                    long_done = 1'b1;
                    long_ev   = 1'b1;
                end
            end
            click[b] = !settled_prev[b] && settled[b];
            settled_prev[b] = settled[b];
        end
        if (long_done)
            click[BTN_MINUS] = 1'b0;
        res.click_next  = click[0];
        res.click_plus  = click[1];
        res.click_minus = click[2];
        res.long_minus  = long_ev;
        return res;
    endfunction

    task automatic check_flag(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        tick_result_t want;
        word_accepted <= in_valid && !in_stall;
        result_taken  <= out_valid && !out_stall;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (bdlp_pkg::cfg_index_t'(cfg_index))
                    bdlp_pkg::CFG_DEBOUNCE: debounce_cfg = cfg_data;
                    bdlp_pkg::CFG_HOLD:     hold_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (click_forecast.size() == 0)
                begin
                    $error("result word arrived with nothing expected");
                    error_count++;
                end
                else
                begin
                    want = click_forecast.pop_front();
                    check_flag("click_next", want.click_next, click_next);
                    check_flag("click_plus", want.click_plus, click_plus);
                    check_flag("click_minus", want.click_minus, click_minus);
                    check_flag("long_minus", want.long_minus, long_minus);
                end
            end
            if (in_valid && !in_stall)
            begin
                click_forecast.push_back(debounce_tick({raw_minus, raw_plus, raw_next}));
                accepted_count++;
            end
        end
    end

    always @(negedge clk)
    begin : sender
        tick_word_t w;
        if (rst_n && (!in_valid || word_accepted))
        begin
            if (tick_queue.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (tick_queue[0].gap != 0)
            begin
                tick_queue[0].gap = tick_queue[0].gap - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                w = tick_queue.pop_front();
                in_valid  <= 1'b1;
                raw_next  <= w.raw[0];
                raw_plus  <= w.raw[1];
                raw_minus <= w.raw[2];
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        int unsigned pause;
        if (hold_ticket != hold_seen)
        begin
            hold_seen <= hold_ticket;
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (result_taken)
        begin
            pause = $urandom_range(0, rx_max_gap);
            rx_wait   <= (pause == 0) ? 0 : pause - 1;
            out_stall <= (pause != 0);
        end
        else if (rx_wait != 0)
        begin
            rx_wait   <= rx_wait - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic push_tick(input logic [2:0] raw);
        tick_word_t w;
        w.raw = raw;
        w.gap = $urandom_range(0, tx_max_gap);
        tick_queue.push_back(w);
        queued_count++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (accepted_count != queued_count || click_forecast.size() != 0);
    endtask

    task automatic write_reg(input bdlp_pkg::cfg_index_t idx,
                             input logic [bdlp_pkg::CFG_WIDTH-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_timing(input logic [bdlp_pkg::CFG_WIDTH-1:0] deb,
                              input logic [bdlp_pkg::CFG_WIDTH-1:0] hold);
        wait_idle();
        repeat (4) @(negedge clk);
        write_reg(bdlp_pkg::CFG_DEBOUNCE, deb);
        write_reg(bdlp_pkg::CFG_HOLD, hold);
    endtask

    // Each button follows runs of steady levels; most runs outlast the debounce
    // time, the rest are short and mostly bounces, and a few words are pure noise.
    task automatic run_random(input int unsigned n, input int unsigned deb,
                              input int unsigned hold);
        logic [2:0]  level;
        int unsigned run [3];
        level = 3'b111;
        run   = '{0, 0, 0};
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                push_tick(3'($urandom));
            end
            else
            begin
                for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++)
                begin
                    if (run[b] == 0)
                    begin
                        level[b] = ~level[b];
                        if ($urandom_range(0, 9) < 7)
                            run[b] = $urandom_range(deb + 1,
                                         deb + ((b == BTN_MINUS) ? hold : 0) + 8);
                        else
                            run[b] = $urandom_range(1, deb + 1);
                    end
                    run[b] = run[b] - 1;
                end
                push_tick(level);
            end
        end
    endtask

    initial
    begin
        reset_predictor();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero debounce and zero hold: presses register at once and the long
        // press fires on the tick the press begins.
        tx_max_gap = 3;
        rx_max_gap = 3;
        set_timing(16'd0, 16'd0);
        push_tick(3'b111);
        push_tick(3'b000);
        push_tick(3'b000);
        push_tick(3'b111);
        push_tick(3'b110);
        push_tick(3'b101);
        push_tick(3'b011);
        push_tick(3'b111);
        push_tick(3'b010);
        push_tick(3'b101);
        push_tick(3'b111);

        set_timing(16'd1, 16'd2);
        push_tick(3'b000);
        push_tick(3'b111);
        push_tick(3'b000);
        push_tick(3'b000);
        push_tick(3'b000);
        push_tick(3'b000);
        push_tick(3'b000);
        push_tick(3'b111);
        push_tick(3'b111);
        push_tick(3'b111);
        push_tick(3'b011);
        push_tick(3'b011);
        push_tick(3'b111);
        push_tick(3'b111);

        tx_max_gap = 12;
        rx_max_gap = 12;
        set_timing(16'd0, 16'd0);
        run_random(240, 0, 0);

        tx_max_gap = 0;
        rx_max_gap = 0;
        set_timing(16'd1, 16'd3);
        run_random(240, 1, 3);

        tx_max_gap = 12;
        rx_max_gap = 12;
        set_timing(16'd2, 16'd8);
        run_random(240, 2, 8);
        @(posedge clk);
        hold_ticket++;

        tx_max_gap = 12;
        rx_max_gap = 0;
        set_timing(16'd3, 16'd1);
        run_random(240, 3, 1);

        tx_max_gap = 12;
        rx_max_gap = 12;
        set_timing(16'd5, 16'd20);
        run_random(240, 5, 20);

        // Widest settings in turn: no level reaches the debounce count, then the
        // minus press settles but misses the hold count, so no long press fires.
        tx_max_gap = 0;
        rx_max_gap = 0;
        set_timing(16'hFFFF, 16'd0);
        for (int k = 0; k < 20; k++)
            push_tick(3'b000);
        set_timing(16'd0, 16'hFFFF);
        for (int k = 0; k < 20; k++)
            push_tick(3'b011);
        push_tick(3'b111);
        push_tick(3'b111);

        wait_idle();
        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("button_debounce_long_press test passed");
        else
            $display("button_debounce_long_press test failed");
        $finish;
    end

    initial
    begin
        #(8_000_000);
        $display("button_debounce_long_press test failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/bdlp_pkg.sv
rtl/core/bdlp_button.sv
rtl/core/bdlp_hold.sv
rtl/core/button_debounce_long_press.sv
sim/button_debounce_long_press_tb.sv
